FILE: rtl/ptm_pkg.sv
package ptm_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int THR_BITS       = 15;
  localparam int PIPE_STAGES    = 8;
  localparam int OUT_DW         = 8;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_X   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_Y   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_Z   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd3;

endpackage

FILE: rtl/point_on_triangle_mesh_test_unit.sv
// Point-on-mesh test: load the query point and plane threshold through the
// cfg_ channel, then stream one triangle per transaction on in_ with tlast on
// the final triangle of a mesh. Each triangle yields one out_ transaction with
// its own hit, the running any-hit of the mesh, and tlast copied through; the
// any-hit clears after the tlast triangle. One triangle is taken every cycle
// while out_ is not back-pressured; each result passes the eight-stage
// datapath, whose exact squared plane compare is split into partial products
// across two of those stages, and then an output register. Back-pressure
// stalls only the occupied stages, so bubbles still fill while a result waits.
module point_on_triangle_mesh_test_unit import ptm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z; zero padding above
  input  logic [((9*COORD_BITS+7)/8)*8-1:0]        in_tdata,
  input  logic                                     in_tlast,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // tri_hit, any_hit; zero padding above
  output logic [OUT_DW-1:0]                        out_tdata,
  output logic                                     out_tlast,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]                  cfg_index,
  input  logic [((COORD_BITS > THR_BITS) ? COORD_BITS : THR_BITS)-1:0] cfg_data
);

  localparam int NS = PIPE_STAGES;
  localparam int TW = 2 * THR_BITS;

  logic [COORD_BITS-1:0] px_r;
  logic [COORD_BITS-1:0] py_r;
  logic [COORD_BITS-1:0] pz_r;
  logic [THR_BITS-1:0]   thr_r;
  logic [TW-1:0]         thr_sq_r;

  logic [NS:0]           en;
  logic [NS-1:0]         v_r;
  logic [NS-1:0]         v_nxt;
  logic [NS-1:0]         last_r;
  logic [NS-1:0]         last_nxt;

  logic                  dp_hit;
  logic                  any_nxt;
  logic                  hit_seen_nxt;
  logic                  hit_seen_r;
  logic                  out_tvalid_r;
  logic                  out_hit_r;
  logic                  out_any_r;
  logic                  out_last_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r     <= '0;
      py_r     <= '0;
      pz_r     <= '0;
      thr_r    <= '0;
      thr_sq_r <= '0;
    end else begin
      thr_sq_r <= TW'(thr_r) * TW'(thr_r);
      if (cfg_valid) begin
        case (cfg_index)
          CFG_POINT_X:   px_r  <= cfg_data[COORD_BITS-1:0];
          CFG_POINT_Y:   py_r  <= cfg_data[COORD_BITS-1:0];
          CFG_POINT_Z:   pz_r  <= cfg_data[COORD_BITS-1:0];
          CFG_THRESHOLD: thr_r <= cfg_data[THR_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // advance a stage when it is empty or its content moves on
  always_comb begin
    en[NS] = !out_tvalid_r || out_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0]    = en[0] ? in_tvalid : v_r[0];
    last_nxt[0] = en[0] ? in_tlast : last_r[0];
    for (int k = 1; k < NS; k++) begin
      v_nxt[k]    = en[k] ? v_r[k-1] : v_r[k];
      last_nxt[k] = en[k] ? last_r[k-1] : last_r[k];
    end
  end

  assign in_tready = en[0];

  ptm_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk      (clk),
    .en       (en[NS-1:0]),
    .tri_data (in_tdata[9*COORD_BITS-1:0]),
    .point_x  (px_r),
    .point_y  (py_r),
    .point_z  (pz_r),
    .thr_sq   (thr_sq_r),
    .hit      (dp_hit)
  );

  assign any_nxt      = hit_seen_r | dp_hit;
  assign hit_seen_nxt = last_r[NS-1] ? 1'b0 : any_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r          <= '0;
      out_tvalid_r <= 1'b0;
      hit_seen_r   <= 1'b0;
    end else begin
      v_r <= v_nxt;
      if (en[NS]) begin
        out_tvalid_r <= v_r[NS-1];
      end
      if (en[NS] && v_r[NS-1]) begin
        hit_seen_r <= hit_seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    if (en[NS]) begin
      out_hit_r  <= dp_hit;
      out_any_r  <= any_nxt;
      out_last_r <= last_r[NS-1];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DW-2){1'b0}}, out_any_r, out_hit_r};
  assign out_tlast  = out_last_r;

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (en[NS] && v_r[NS-1] && last_r[NS-1]) |=> !hit_seen_r)
    else $error("any-hit not cleared after last triangle");

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> ((&v_r) && out_tvalid_r))
    else $error("input held off with a free stage");

  a_stall_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready && !in_tvalid) |=>
      ($countones(v_r) == $past($countones(v_r))))
    else $error("transaction lost or repeated during stall");

endmodule

FILE: rtl/ptm_datapath.sv
module ptm_datapath import ptm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic [PIPE_STAGES-1:0]    en,
  input  logic [9*COORD_BITS-1:0]   tri_data,
  input  logic [COORD_BITS-1:0]     point_x,
  input  logic [COORD_BITS-1:0]     point_y,
  input  logic [COORD_BITS-1:0]     point_z,
  input  logic [2*THR_BITS-1:0]     thr_sq,
  output logic                      hit
);

  localparam int C    = COORD_BITS;
  localparam int EW   = C + 1;
  localparam int PW   = 2 * EW;
  localparam int NW   = PW + 1;
  localparam int DW   = PW + 2;
  localparam int DNPW = NW + EW;
  localparam int DNW  = DNPW + 2;
  localparam int NPW  = 2 * NW;
  localparam int NNW  = NPW + 2;
  localparam int NU   = NNW - 1;
  localparam int DPW  = 2 * DW;
  localparam int DEW  = DPW + 1;
  localparam int LO   = DNW / 2;
  localparam int HI   = DNW - LO;
  localparam int LL   = 2 * LO;
  localparam int HL   = HI + LO;
  localparam int HH   = 2 * HI;
  localparam int SQW  = 2 * DNW;
  localparam int TW   = 2 * THR_BITS;
  localparam int K    = (NU + 2) / 3;
  localparam int PRW  = TW + K;
  localparam int RW   = TW + 3 * K;
  localparam int CMPW = (SQW > RW) ? SQW : RW;

  localparam int D00 = 0;
  localparam int D01 = 1;
  localparam int D02 = 2;
  localparam int D11 = 3;
  localparam int D12 = 4;

  logic signed [C-1:0]    va [3];
  logic signed [C-1:0]    vb [3];
  logic signed [C-1:0]    vc [3];
  logic signed [C-1:0]    pt [3];

  logic signed [EW-1:0]   e1_nxt [3];
  logic signed [EW-1:0]   e2_nxt [3];
  logic signed [EW-1:0]   w0_nxt [3];
  logic signed [EW-1:0]   e1_r [3];
  logic signed [EW-1:0]   e2_r [3];
  logic signed [EW-1:0]   w0_r [3];

  logic signed [PW-1:0]   pn_nxt [6];
  logic signed [PW-1:0]   pd_nxt [5][3];
  logic signed [PW-1:0]   pn_r [6];
  logic signed [PW-1:0]   pd_r [5][3];
  logic signed [EW-1:0]   w1_r [3];

  logic signed [NW-1:0]   n_nxt [3];
  logic signed [DW-1:0]   d_nxt [5];
  logic signed [NW-1:0]   n_r [3];
  logic signed [DW-1:0]   d_r [5];
  logic signed [EW-1:0]   w2_r [3];

  logic signed [DNPW-1:0] pdn_nxt [3];
  logic signed [NPW-1:0]  pnn_nxt [3];
  logic signed [DPW-1:0]  pdd_nxt [6];
  logic signed [DNPW-1:0] pdn_r [3];
  logic signed [NPW-1:0]  pnn_r [3];
  logic signed [DPW-1:0]  pdd_r [6];

  logic signed [DNW-1:0]  dn_nxt;
  logic signed [NNW-1:0]  nn_nxt;
  logic signed [DEW-1:0]  den_nxt;
  logic signed [DEW-1:0]  nu_nxt;
  logic signed [DEW-1:0]  nv_nxt;
  logic signed [DNW-1:0]  dn_r;
  logic signed [NNW-1:0]  nn_r;
  logic signed [DEW-1:0]  den_r;
  logic signed [DEW-1:0]  nu_r;
  logic signed [DEW-1:0]  nv_r;

  logic [DNW-1:0]         dn_mag;
  logic [3*K-1:0]         nn_pad;
  logic signed [DEW:0]    uv_sum;
  logic signed [DEW:0]    den_ext;
  logic [LL-1:0]          pll_nxt;
  logic [HL-1:0]          phl_nxt;
  logic [HH-1:0]          phh_nxt;
  logic [PRW-1:0]         pr_nxt [3];
  logic                   inside5_nxt;
  logic [LL-1:0]          pll_r;
  logic [HL-1:0]          phl_r;
  logic [HH-1:0]          phh_r;
  logic [PRW-1:0]         pr_r [3];
  logic                   inside5_r;

  logic [SQW-1:0]         dnsq_nxt;
  logic [RW-1:0]          rhs_nxt;
  logic [SQW-1:0]         dnsq_r;
  logic [RW-1:0]          rhs_r;
  logic                   inside6_r;

  logic                   hit_nxt;
  logic                   hit_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = tri_data[i*C +: C];
      vb[i] = tri_data[(3+i)*C +: C];
      vc[i] = tri_data[(6+i)*C +: C];
    end
    pt[0] = point_x;
    pt[1] = point_y;
    pt[2] = point_z;
    for (int i = 0; i < 3; i++) begin
      e1_nxt[i] = EW'(vb[i]) - EW'(va[i]);
      e2_nxt[i] = EW'(vc[i]) - EW'(va[i]);
      w0_nxt[i] = EW'(pt[i]) - EW'(va[i]);
    end
  end

  always_comb begin
    pn_nxt[0] = PW'(e1_r[1]) * PW'(e2_r[2]);
    pn_nxt[1] = PW'(e1_r[2]) * PW'(e2_r[1]);
    pn_nxt[2] = PW'(e1_r[2]) * PW'(e2_r[0]);
    pn_nxt[3] = PW'(e1_r[0]) * PW'(e2_r[2]);
    pn_nxt[4] = PW'(e1_r[0]) * PW'(e2_r[1]);
    pn_nxt[5] = PW'(e1_r[1]) * PW'(e2_r[0]);
    for (int i = 0; i < 3; i++) begin
      pd_nxt[D00][i] = PW'(e1_r[i]) * PW'(e1_r[i]);
      pd_nxt[D01][i] = PW'(e1_r[i]) * PW'(e2_r[i]);
      pd_nxt[D02][i] = PW'(e1_r[i]) * PW'(w0_r[i]);
      pd_nxt[D11][i] = PW'(e2_r[i]) * PW'(e2_r[i]);
      pd_nxt[D12][i] = PW'(e2_r[i]) * PW'(w0_r[i]);
    end
  end

  always_comb begin
    n_nxt[0] = NW'(pn_r[0]) - NW'(pn_r[1]);
    n_nxt[1] = NW'(pn_r[2]) - NW'(pn_r[3]);
    n_nxt[2] = NW'(pn_r[4]) - NW'(pn_r[5]);
    for (int j = 0; j < 5; j++) begin
      d_nxt[j] = DW'(pd_r[j][0]) + DW'(pd_r[j][1]) + DW'(pd_r[j][2]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pdn_nxt[i] = DNPW'(n_r[i]) * DNPW'(w2_r[i]);
      pnn_nxt[i] = NPW'(n_r[i]) * NPW'(n_r[i]);
    end
    pdd_nxt[0] = DPW'(d_r[D00]) * DPW'(d_r[D11]);
    pdd_nxt[1] = DPW'(d_r[D01]) * DPW'(d_r[D01]);
    pdd_nxt[2] = DPW'(d_r[D11]) * DPW'(d_r[D02]);
    pdd_nxt[3] = DPW'(d_r[D01]) * DPW'(d_r[D12]);
    pdd_nxt[4] = DPW'(d_r[D00]) * DPW'(d_r[D12]);
    pdd_nxt[5] = DPW'(d_r[D01]) * DPW'(d_r[D02]);
  end

  always_comb begin
    dn_nxt  = DNW'(pdn_r[0]) + DNW'(pdn_r[1]) + DNW'(pdn_r[2]);
    nn_nxt  = NNW'(pnn_r[0]) + NNW'(pnn_r[1]) + NNW'(pnn_r[2]);
    den_nxt = DEW'(pdd_r[0]) - DEW'(pdd_r[1]);
    nu_nxt  = DEW'(pdd_r[2]) - DEW'(pdd_r[3]);
    nv_nxt  = DEW'(pdd_r[4]) - DEW'(pdd_r[5]);
  end

  always_comb begin
    dn_mag  = dn_r[DNW-1] ? DNW'(-dn_r) : DNW'(dn_r);
    pll_nxt = LL'(dn_mag[LO-1:0]) * LL'(dn_mag[LO-1:0]);
    phl_nxt = HL'(dn_mag[DNW-1:LO]) * HL'(dn_mag[LO-1:0]);
    phh_nxt = HH'(dn_mag[DNW-1:LO]) * HH'(dn_mag[DNW-1:LO]);
    nn_pad  = (3*K)'(nn_r[NU-1:0]);
    for (int i = 0; i < 3; i++) begin
      pr_nxt[i] = PRW'(thr_sq) * PRW'(nn_pad[i*K +: K]);
    end
    uv_sum      = (DEW+1)'(nu_r) + (DEW+1)'(nv_r);
    den_ext     = (DEW+1)'(den_r);
    inside5_nxt = (den_r != '0) && !nu_r[DEW-1] && !nv_r[DEW-1] && (uv_sum <= den_ext);
  end

  always_comb begin
    dnsq_nxt = SQW'(pll_r) + (SQW'(phl_r) << (LO + 1)) + (SQW'(phh_r) << LL);
    rhs_nxt  = RW'(pr_r[0]) + (RW'(pr_r[1]) << K) + (RW'(pr_r[2]) << (2 * K));
    hit_nxt  = inside6_r && (CMPW'(dnsq_r) < CMPW'(rhs_r));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      e1_r <= e1_nxt;
      e2_r <= e2_nxt;
      w0_r <= w0_nxt;
    end
    if (en[1]) begin
      pn_r <= pn_nxt;
      pd_r <= pd_nxt;
      w1_r <= w0_r;
    end
    if (en[2]) begin
      n_r  <= n_nxt;
      d_r  <= d_nxt;
      w2_r <= w1_r;
    end
    if (en[3]) begin
      pdn_r <= pdn_nxt;
      pnn_r <= pnn_nxt;
      pdd_r <= pdd_nxt;
    end
    if (en[4]) begin
      dn_r  <= dn_nxt;
      nn_r  <= nn_nxt;
      den_r <= den_nxt;
      nu_r  <= nu_nxt;
      nv_r  <= nv_nxt;
    end
    if (en[5]) begin
      pll_r     <= pll_nxt;
      phl_r     <= phl_nxt;
      phh_r     <= phh_nxt;
      pr_r      <= pr_nxt;
      inside5_r <= inside5_nxt;
    end
    if (en[6]) begin
      dnsq_r    <= dnsq_nxt;
      rhs_r     <= rhs_nxt;
      inside6_r <= inside5_r;
    end
    if (en[7]) begin
      hit_r <= hit_nxt;
    end
  end

  assign hit = hit_r;

endmodule

FILE: verif/ptm_mesh_checker.sv
module ptm_mesh_checker
  import ptm_pkg::*;
(
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  input  logic                                   in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z; zero padding above
  input  logic [((9*COORD_BITS_DEF+7)/8)*8-1:0]  in_tdata,
  input  logic                                   in_tlast,
  input  logic                                   out_tvalid,
  input  logic                                   out_tready,
  // tri_hit, any_hit; zero padding above
  input  logic [OUT_DW-1:0]                      out_tdata,
  input  logic                                   out_tlast,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]                cfg_index,
  input  logic [COORD_BITS_DEF-1:0]              cfg_data,
  output int                                     fails,
  output int                                     pending,
  output int                                     results,
  output int                                     hits,
  output int                                     meshes
);

  localparam int MAX_PRINTS = 40;

  typedef logic signed [191:0] wide_t;
  typedef logic [8:0][COORD_BITS_DEF-1:0] tri_coords_t;

  typedef struct packed {
    logic tri_hit;
    logic any_hit;
    logic mesh_done;
  } verdict_t;

  verdict_t                   hit_verdicts[$];
  logic [COORD_BITS_DEF-1:0]  pt[3];
  logic [THR_BITS-1:0]        thr;
  logic                       mesh_hit_seen;

  function automatic logic point_on_tri(input tri_coords_t crd);
    wide_t a[3], b[3], c[3], p[3], e1[3], e2[3], w[3], n[3];
    wide_t dn, nn, t, d00, d01, d02, d11, d12, den, nu, nv;
    for (int i = 0; i < 3; i++) begin
      a[i]  = wide_t'(signed'(crd[i]));
      b[i]  = wide_t'(signed'(crd[3+i]));
      c[i]  = wide_t'(signed'(crd[6+i]));
      p[i]  = wide_t'(signed'(pt[i]));
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
      w[i]  = p[i] - a[i];
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    dn = n[0] * w[0] + n[1] * w[1] + n[2] * w[2];
    nn = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    t  = wide_t'(thr);
    // squared distance compare, strict
    if (!(dn * dn < t * t * nn)) return 1'b0;
    d00 = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
    d01 = e1[0] * e2[0] + e1[1] * e2[1] + e1[2] * e2[2];
    d02 = e1[0] * w[0]  + e1[1] * w[1]  + e1[2] * w[2];
    d11 = e2[0] * e2[0] + e2[1] * e2[1] + e2[2] * e2[2];
    d12 = e2[0] * w[0]  + e2[1] * w[1]  + e2[2] * w[2];
    den = d00 * d11 - d01 * d01;
    if (den == 0) return 1'b0;
    nu = d11 * d02 - d01 * d12;
    nv = d00 * d12 - d01 * d02;
    if (nu < 0 || nv < 0) return 1'b0;
    return !(den < nu + nv);
  endfunction

  task automatic flag(input string what, input logic got, input logic want);
    fails++;
    if (fails <= MAX_PRINTS)
      $display("mismatch on result %0d: %s got %b expected %b", results, what, got, want);
  endtask

  always @(posedge clk) begin
    verdict_t due;
    verdict_t now_v;
    if (!rst_n) begin
      hit_verdicts.delete();
      pt[0] = '0;
      pt[1] = '0;
      pt[2] = '0;
      thr = '0;
      mesh_hit_seen = 1'b0;
      fails = 0;
      results = 0;
      hits = 0;
      meshes = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (hit_verdicts.size() == 0) begin
          flag("result with none outstanding, tri_hit", out_tdata[0], 1'b0);
        end else begin
          due = hit_verdicts.pop_front();
          if (out_tdata[0] !== due.tri_hit) flag("tri_hit", out_tdata[0], due.tri_hit);
          if (out_tdata[1] !== due.any_hit) flag("any_hit", out_tdata[1], due.any_hit);
          if (out_tlast !== due.mesh_done) flag("mesh_done", out_tlast, due.mesh_done);
        end
        results++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POINT_X:   pt[0] = cfg_data;
          CFG_POINT_Y:   pt[1] = cfg_data;
          CFG_POINT_Z:   pt[2] = cfg_data;
          CFG_THRESHOLD: thr = cfg_data[THR_BITS-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        now_v.tri_hit   = point_on_tri(in_tdata);
        now_v.any_hit   = mesh_hit_seen | now_v.tri_hit;
        now_v.mesh_done = in_tlast;
        mesh_hit_seen   = in_tlast ? 1'b0 : now_v.any_hit;
        hit_verdicts    = {hit_verdicts, now_v};
        if (now_v.tri_hit) hits++;
        if (in_tlast) meshes++;
      end
    end
    pending = hit_verdicts.size();
  end

endmodule

FILE: verif/tb_point_on_triangle_mesh_test_unit.sv
module tb_point_on_triangle_mesh_test_unit;
  import ptm_pkg::*;

  localparam int IN_DW           = ((9*COORD_BITS_DEF+7)/8)*8;
  localparam int CFG_DW          = (COORD_BITS_DEF > THR_BITS) ? COORD_BITS_DEF : THR_BITS;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int SETTLE          = PIPE_STAGES + 4;

  typedef enum {TRI_CENTROID, TRI_EDGE, TRI_VERTEX, TRI_OUTSIDE} shape_t;
  typedef logic [8:0][COORD_BITS_DEF-1:0] tri_coords_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DW-1:0]         in_tdata;
  logic                     in_tlast;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_DW-1:0]        out_tdata;
  logic                     out_tlast;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DW-1:0]        cfg_data;

  int fails, pending, results, hits, meshes;
  int px[3];
  int burst_left;
  int n_sent;
  int n_settings;

  point_on_triangle_mesh_test_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ptm_mesh_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fails      (fails),
    .pending    (pending),
    .results    (results),
    .hits       (hits),
    .meshes     (meshes)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("timeout: mesh tester stopped making progress");
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int mode;
    int len;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      case (mode)
        0: begin
          len = $urandom_range(20, 80);
          repeat (len) @(negedge clk) out_tready <= 1'b1;
        end
        1: begin
          len = $urandom_range(10, 40);
          repeat (len) @(negedge clk) out_tready <= 1'($urandom_range(0, 1));
        end
        2: begin
          len = $urandom_range(5, 30);
          repeat (len) @(negedge clk) out_tready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          len = $urandom_range(1, 24);
          repeat (len) @(negedge clk) out_tready <= 1'b0;
          @(negedge clk) out_tready <= 1'b1;
        end
      endcase
    end
  end

  function automatic int srand(input int s);
    return int'($urandom_range(0, 2 * s)) - s;
  endfunction

  function automatic bit fits(input int v);
    return v >= -32768 && v <= 32767;
  endfunction

  function automatic int pick_spread();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(1, 16);
    if (r < 8) return $urandom_range(1, 600);
    return $urandom_range(1, 32767);
  endfunction

  function automatic tri_coords_t pack_tri(input int a[3], input int b[3], input int c[3]);
    tri_coords_t t;
    for (int i = 0; i < 3; i++) begin
      t[i]   = COORD_BITS_DEF'(a[i]);
      t[3+i] = COORD_BITS_DEF'(b[i]);
      t[6+i] = COORD_BITS_DEF'(c[i]);
    end
    return t;
  endfunction

  // shrink the spread until every vertex fits the coordinate range
  function automatic void build_tri(input shape_t kind, input int spread,
                                    output int a[3], output int b[3], output int c[3]);
    int s;
    int da[3];
    int db[3];
    bit ok;
    s = spread;
    ok = 1'b0;
    while (!ok) begin
      for (int i = 0; i < 3; i++) begin
        da[i] = srand(s);
        db[i] = srand(s);
        case (kind)
          TRI_CENTROID: begin
            a[i] = px[i] + da[i];
            b[i] = px[i] + db[i];
            c[i] = px[i] - da[i] - db[i];
          end
          TRI_EDGE: begin
            a[i] = px[i] + da[i];
            b[i] = px[i] - da[i];
            c[i] = px[i] + db[i];
          end
          TRI_VERTEX: begin
            a[i] = px[i];
            b[i] = px[i] + da[i];
            c[i] = px[i] + db[i];
          end
          default: begin
            a[i] = px[i] + da[i];
            b[i] = px[i] + db[i];
            c[i] = px[i] + da[i] + db[i];
          end
        endcase
      end
      ok = 1'b1;
      for (int i = 0; i < 3; i++)
        if (!fits(a[i]) || !fits(b[i]) || !fits(c[i])) ok = 1'b0;
      s = s / 2;
    end
  endfunction

  task automatic send_tri(input tri_coords_t t, input logic last);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_shape(input shape_t kind, input int spread, input logic last);
    int a[3], b[3], c[3];
    build_tri(kind, spread, a, b, c);
    send_tri(pack_tri(a, b, c), last);
  endtask

  // triangle parallel to the xy plane, offset in z from the query point
  task automatic send_flat(input int off, input logic last);
    int a[3], b[3], c[3];
    a = '{px[0] + 100, px[1],      px[2] + off};
    b = '{px[0] - 50,  px[1] + 87, px[2] + off};
    c = '{px[0] - 50,  px[1] - 87, px[2] + off};
    send_tri(pack_tri(a, b, c), last);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_point(input int x, input int y, input int z,
                            input logic [CFG_DW-1:0] thr);
    logic [CFG_IDX_BITS-1:0] regs[4];
    logic [CFG_DW-1:0]       vals[4];
    int first;
    regs[0] = CFG_POINT_X;
    regs[1] = CFG_POINT_Y;
    regs[2] = CFG_POINT_Z;
    regs[3] = CFG_THRESHOLD;
    vals[0] = CFG_DW'(x);
    vals[1] = CFG_DW'(y);
    vals[2] = CFG_DW'(z);
    vals[3] = thr;
    settle();
    first = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++) write_reg(regs[(first + k) % 4], vals[(first + k) % 4]);
    cfg_valid <= 1'b0;
    px[0] = 32'(signed'(vals[0]));
    px[1] = 32'(signed'(vals[1]));
    px[2] = 32'(signed'(vals[2]));
    n_settings++;
  endtask

  task automatic random_tri();
    int a[3], b[3], c[3], tmp[3];
    int r;
    int jr;
    shape_t kind;
    tri_coords_t t;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      kind = (r < 45) ? TRI_CENTROID : (r < 55) ? TRI_EDGE : (r < 62) ? TRI_VERTEX :
             (r < 70) ? TRI_OUTSIDE : TRI_CENTROID;
      build_tri(kind, pick_spread(), a, b, c);
      if (r >= 70) begin
        jr = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 64);
        for (int i = 0; i < 3; i++) c[i] = c[i] + srand(jr);
      end
      if ($urandom_range(0, 1) == 1) begin
        tmp = b;
        b = c;
        c = tmp;
      end
      t = pack_tri(a, b, c);
    end else if (r < 90) begin
      t = IN_DW'({$urandom, $urandom, $urandom, $urandom, $urandom});
    end else begin
      build_tri(TRI_CENTROID, pick_spread(), a, b, c);
      b = a;
      t = pack_tri(a, b, c);
    end
    send_tri(t, $urandom_range(0, 5) == 0);
  endtask

  initial begin
    int a[3], b[3], c[3];
    int guard;
    logic [CFG_DW-1:0] thr;
    int r;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_POINT_X;
    cfg_data   = '0;
    px         = '{0, 0, 0};
    burst_left = 0;
    n_sent     = 0;
    n_settings = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // registers still at reset: zero threshold, nothing may hit
    send_shape(TRI_CENTROID, 300, 1'b0);
    send_shape(TRI_VERTEX, 300, 1'b1);

    load_point(256, -512, 768, CFG_DW'(8));
    send_shape(TRI_CENTROID, 200, 1'b0);
    send_shape(TRI_OUTSIDE, 5000, 1'b0);
    send_tri(pack_tri(px, px, px), 1'b1);
    build_tri(TRI_EDGE, 300, a, b, c);
    send_tri(pack_tri(a, b, px), 1'b0);
    send_shape(TRI_VERTEX, 100, 1'b0);
    send_shape(TRI_EDGE, 100, 1'b0);
    send_shape(TRI_OUTSIDE, 100, 1'b1);
    send_flat(7, 1'b0);
    send_flat(8, 1'b0);
    send_flat(-8, 1'b0);
    send_flat(-7, 1'b1);
    send_tri({9{16'h8000}}, 1'b0);
    send_tri({9{16'h7fff}}, 1'b0);
    a = '{-32768, -32768, -32768};
    b = '{32767, -32768, -32768};
    c = '{-32768, 32767, 32767};
    send_tri(pack_tri(a, b, c), 1'b1);
    send_tri(pack_tri(a, c, b), 1'b0);
    send_tri(IN_DW'({$urandom, $urandom, $urandom, $urandom, $urandom}), 1'b1);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        load_point(-32768, -32768, -32768, '1);
      end else if (ph == 1) begin
        load_point(32767, 32767, 32767, '0);
      end else begin
        r = $urandom_range(0, 2);
        thr = CFG_DW'((r == 0) ? $urandom_range(1, 4) : (r == 1) ? $urandom_range(1, 64) :
              $urandom_range(0, 65535));
        if ($urandom_range(0, 1) == 0)
          load_point(srand(4096), srand(4096), srand(4096), thr);
        else
          load_point(srand(32767), srand(32767), srand(32767), thr);
      end
      repeat (ITEMS_PER_PHASE) random_tri();
    end

    in_tvalid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE) @(negedge clk);
    if (pending != 0) $display("%0d triangle results never arrived", pending);
    $display("covered %0d triangles under %0d register settings, %0d meshes closed",
             n_sent, n_settings, meshes);
    $display("checked %0d results, %0d of them hits", results, hits);
    if (fails == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
